### rtl/core/infix_to_postfix_converter_core_macros.svh
// ---------------------------------------------------------------------------
// Infix-to-postfix converter assertion macros
// Shared concurrent-assertion shorthands, sampled on clk and
// disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication
`define ITP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/itp_pkg.sv
// ---------------------------------------------------------------------------
// Infix-to-postfix converter package
// Operator codes, character constants, error codes and decode helpers.
// ---------------------------------------------------------------------------
package itp_pkg;

	// Default operator stack depth
	localparam int STACK_DEPTH_DEF = 32;

	// ASCII characters of interest
	localparam logic [7:0] CHAR_OPEN  = 8'h28;
	localparam logic [7:0] CHAR_CLOSE = 8'h29;
	localparam logic [7:0] CHAR_MUL   = 8'h2A;
	localparam logic [7:0] CHAR_ADD   = 8'h2B;
	localparam logic [7:0] CHAR_SUB   = 8'h2D;
	localparam logic [7:0] CHAR_DIV   = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	// Stacked operator codes
	typedef enum logic [2:0] {
		OP_OPEN = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_code_t;

	// Expression error codes
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_CLOSE    = 2'd1,
		ERR_OPEN     = 2'd2,
		ERR_OVERFLOW = 2'd3
	} err_code_t;

	// Input word classes
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_DIGIT,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OP,
		CLS_END
	} cls_t;

	// Precedence: '(' lowest so an operator never pops it
	function automatic logic [1:0] op_rank(op_code_t code);
		logic [1:0] r;
		case (code)
			OP_ADD, OP_SUB: r = 2'd2;
			OP_MUL, OP_DIV: r = 2'd3;
			default:        r = 2'd1;
		endcase
		return r;
	endfunction

	// Character emitted for a popped operator
	function automatic logic [7:0] op_char(op_code_t code);
		logic [7:0] c;
		case (code)
			OP_OPEN: c = CHAR_OPEN;
			OP_ADD:  c = CHAR_ADD;
			OP_SUB:  c = CHAR_SUB;
			OP_MUL:  c = CHAR_MUL;
			OP_DIV:  c = CHAR_DIV;
			default: c = CHAR_NUL;
		endcase
		return c;
	endfunction

	// Operator code of an arithmetic character
	function automatic op_code_t op_of_char(logic [7:0] ch);
		op_code_t code;
		case (ch)
			CHAR_ADD: code = OP_ADD;
			CHAR_SUB: code = OP_SUB;
			CHAR_MUL: code = OP_MUL;
			CHAR_DIV: code = OP_DIV;
			default:  code = OP_OPEN;
		endcase
		return code;
	endfunction

	// Sort an input word into its class
	function automatic cls_t classify(logic kind, logic [7:0] ch);
		cls_t cls;
		if (kind) begin
			cls = CLS_END;
		end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
			cls = CLS_DIGIT;
		end else begin
			case (ch)
				CHAR_OPEN:  cls = CLS_OPEN;
				CHAR_CLOSE: cls = CLS_CLOSE;
				CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV: cls = CLS_OP;
				default:    cls = CLS_NONE;
			endcase
		end
		return cls;
	endfunction

endpackage

### rtl/core/itp_if.sv
// ---------------------------------------------------------------------------
// Infix-to-postfix converter channels
// Valid/ready channels for input characters and postfix results.
// ---------------------------------------------------------------------------

// Input channel: one character or end mark per word
interface itp_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] ch;

	modport source (output valid, output kind, output ch, input ready);
	modport sink   (input valid, input kind, input ch, output ready);
endinterface

// Output channel: one postfix symbol or end marker per word
interface itp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       symbol_valid;
	logic       expr_end;
	logic       last;
	logic [1:0] error_code;

	modport source (output valid, output symbol, output symbol_valid, output expr_end,
		output last, output error_code, input ready);
	modport sink   (input valid, input symbol, input symbol_valid, input expr_end,
		input last, input error_code, output ready);
endinterface

### rtl/core/itp_stack_mem.sv
// ---------------------------------------------------------------------------
// Operator stack memory
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module itp_stack_mem #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
	parameter int AW          = $clog2(STACK_DEPTH)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  itp_pkg::op_code_t  wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output itp_pkg::op_code_t  rd_data
);

	itp_pkg::op_code_t mem [STACK_DEPTH];

	// Write stacked operator
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read and hold top candidate until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/infix_to_postfix_converter_core.sv
// ---------------------------------------------------------------------------
// Infix-to-postfix converter core
// Shunting-yard conversion of single-digit infix expressions, operator
// stack held in a synchronous memory.
// ---------------------------------------------------------------------------
// Usage:
//   infix   : one word per character (kind=0) or end of expression (kind=1).
//   postfix : postfix symbols in order; an end word closes with a marker word
//             (symbol_valid=0, expr_end=1) carrying the first error of the
//             expression. last marks the final word caused by an input word.
// Sequencing:
//   A digit appears on postfix in the cycle after acceptance; after a digit,
//   '(' or ignored character the next word is taken once the output is free.
//   A ')', operator or end word that touches a non-empty stack reads the top,
//   examines stacked entries one by one in S_POP, releases the last symbol in
//   S_FIN and, for an end word, sends the marker in S_MARK. The single read
//   port of the stack memory caps pops at one entry per cycle when not stalled.
// Reset:
//   arst_n clears the stack count, the pending error and all valids; stack
//   contents are not cleared and need no clearing pass.
// Stalls:
//   A stalled postfix receiver holds the output word; the core then pauses
//   its pops and accepts no new input until the output register frees up.
// ---------------------------------------------------------------------------
`include "infix_to_postfix_converter_core_macros.svh"

module infix_to_postfix_converter_core #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	itp_in_if.sink     infix,
	itp_out_if.source  postfix
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_FIN,
		S_MARK
	} state_t;

	state_t                state_q;
	itp_pkg::cls_t         cls_q;
	itp_pkg::op_code_t     code_q;
	logic [CW-1:0]         count_q;
	itp_pkg::err_code_t    pending_q;
	logic                  hold_vld_q;
	logic [7:0]            hold_sym_q;

	logic                  out_vld_q;
	logic [7:0]            symbol_q;
	logic                  symbol_valid_q;
	logic                  expr_end_q;
	logic                  last_q;
	itp_pkg::err_code_t    error_code_q;

	// Memory port signals
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	itp_pkg::op_code_t     wr_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	itp_pkg::op_code_t     top;

	// Control decode
	logic                  out_free;
	logic                  accept;
	itp_pkg::cls_t         in_cls;
	itp_pkg::op_code_t     in_code;
	logic [CW-1:0]         cnt_m1;
	logic [CW-1:0]         cnt_m2;
	logic                  take;
	logic                  emit;
	logic                  more;
	logic                  step_ok;
	logic [CW-1:0]         cnt_after;
	logic                  push_full;
	logic                  mark_load;

	assign out_free     = !out_vld_q || postfix.ready;
	assign infix.ready  = (state_q == S_IDLE) && out_free;
	assign accept       = infix.valid && infix.ready;
	assign in_cls       = itp_pkg::classify(infix.kind, infix.ch);
	assign in_code      = itp_pkg::op_of_char(infix.ch);
	assign cnt_m1       = count_q - CW'(1);
	assign cnt_m2       = count_q - CW'(2);

	// Pop step: decide on the entry most recently read
	always_comb begin
		take      = !(cls_q == itp_pkg::CLS_OP &&
			itp_pkg::op_rank(top) < itp_pkg::op_rank(code_q));
		emit      = take && (top != itp_pkg::OP_OPEN);
		more      = take && (cnt_m1 != '0) &&
			!(cls_q == itp_pkg::CLS_CLOSE && top == itp_pkg::OP_OPEN);
		step_ok   = !emit || !hold_vld_q || out_free;
		cnt_after = take ? cnt_m1 : count_q;
		push_full = (cnt_after == CW'(STACK_DEPTH));
	end

	// Stack memory access; reads only hit entries written in earlier cycles
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = itp_pkg::OP_OPEN;
		rd_en   = 1'b0;
		rd_addr = cnt_m1[AW-1:0];
		if (state_q == S_IDLE) begin
			if (accept) begin
				case (in_cls)
					itp_pkg::CLS_OPEN: begin
						wr_en = (count_q != CW'(STACK_DEPTH));
					end
					itp_pkg::CLS_OP: begin
						wr_en   = (count_q == '0);
						wr_data = in_code;
						rd_en   = (count_q != '0);
					end
					itp_pkg::CLS_CLOSE, itp_pkg::CLS_END: begin
						rd_en = (count_q != '0);
					end
					default: begin
					end
				endcase
			end
		end else if (state_q == S_POP && step_ok) begin
			rd_en   = more;
			rd_addr = cnt_m2[AW-1:0];
			wr_en   = (cls_q == itp_pkg::CLS_OP) && !more && !push_full;
			wr_addr = cnt_after[AW-1:0];
			wr_data = code_q;
		end
	end

	itp_stack_mem #(
		.STACK_DEPTH (STACK_DEPTH),
		.AW          (AW)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (top)
	);

	assign mark_load = out_free && ((state_q == S_MARK) ||
		(accept && in_cls == itp_pkg::CLS_END && count_q == '0));

	// Sequencer, stack count, error tracking and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cls_q          <= itp_pkg::CLS_NONE;
			code_q         <= itp_pkg::OP_OPEN;
			count_q        <= '0;
			pending_q      <= itp_pkg::ERR_NONE;
			hold_vld_q     <= 1'b0;
			hold_sym_q     <= '0;
			out_vld_q      <= 1'b0;
			symbol_q       <= '0;
			symbol_valid_q <= 1'b0;
			expr_end_q     <= 1'b0;
			last_q         <= 1'b0;
			error_code_q   <= itp_pkg::ERR_NONE;
		end else begin
			// Drop the output word once taken
			if (postfix.ready) begin
				out_vld_q <= 1'b0;
			end

			// End marker, from idle on an empty stack or after the flush
			if (mark_load) begin
				out_vld_q      <= 1'b1;
				symbol_q       <= itp_pkg::CHAR_NUL;
				symbol_valid_q <= 1'b0;
				expr_end_q     <= 1'b1;
				last_q         <= 1'b1;
				error_code_q   <= pending_q;
				pending_q      <= itp_pkg::ERR_NONE;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cls_q  <= in_cls;
						code_q <= in_code;
						case (in_cls)
							itp_pkg::CLS_DIGIT: begin
								out_vld_q      <= 1'b1;
								symbol_q       <= infix.ch;
								symbol_valid_q <= 1'b1;
								expr_end_q     <= 1'b0;
								last_q         <= 1'b1;
								error_code_q   <= itp_pkg::ERR_NONE;
							end
							itp_pkg::CLS_OPEN: begin
								if (count_q != CW'(STACK_DEPTH)) begin
									count_q <= count_q + CW'(1);
								end else if (pending_q == itp_pkg::ERR_NONE) begin
									pending_q <= itp_pkg::ERR_OVERFLOW;
								end
							end
							itp_pkg::CLS_CLOSE: begin
								if (count_q == '0) begin
									if (pending_q == itp_pkg::ERR_NONE) begin
										pending_q <= itp_pkg::ERR_CLOSE;
									end
								end else begin
									state_q <= S_POP;
								end
							end
							itp_pkg::CLS_OP: begin
								if (count_q == '0) begin
									count_q <= CW'(1);
								end else begin
									state_q <= S_POP;
								end
							end
							itp_pkg::CLS_END: begin
								if (count_q != '0) begin
									state_q <= S_POP;
								end
							end
							default: begin
							end
						endcase
					end
				end

				S_POP: begin
					if (step_ok) begin
						// Advance the stack count, pushing the operator on the last step
						if (cls_q == itp_pkg::CLS_OP && !more && !push_full) begin
							count_q <= cnt_after + CW'(1);
						end else begin
							count_q <= cnt_after;
						end

						// Move symbol through the hold stage so last can be set later
						if (emit) begin
							if (hold_vld_q) begin
								out_vld_q      <= 1'b1;
								symbol_q       <= hold_sym_q;
								symbol_valid_q <= 1'b1;
								expr_end_q     <= 1'b0;
								last_q         <= 1'b0;
								error_code_q   <= itp_pkg::ERR_NONE;
							end
							hold_vld_q <= 1'b1;
							hold_sym_q <= itp_pkg::op_char(top);
						end

						// Record the first error of the expression
						if (pending_q == itp_pkg::ERR_NONE) begin
							if (cls_q == itp_pkg::CLS_END && top == itp_pkg::OP_OPEN) begin
								pending_q <= itp_pkg::ERR_OPEN;
							end else if (cls_q == itp_pkg::CLS_CLOSE &&
								top != itp_pkg::OP_OPEN && cnt_m1 == '0) begin
								pending_q <= itp_pkg::ERR_CLOSE;
							end else if (cls_q == itp_pkg::CLS_OP && !more && push_full) begin
								pending_q <= itp_pkg::ERR_OVERFLOW;
							end
						end

						if (!more) begin
							state_q <= S_FIN;
						end
					end
				end

				S_FIN: begin
					// Release the held symbol as the closing word of the item
					if (!hold_vld_q || out_free) begin
						if (hold_vld_q) begin
							out_vld_q      <= 1'b1;
							symbol_q       <= hold_sym_q;
							symbol_valid_q <= 1'b1;
							expr_end_q     <= 1'b0;
							last_q         <= (cls_q != itp_pkg::CLS_END);
							error_code_q   <= itp_pkg::ERR_NONE;
						end
						hold_vld_q <= 1'b0;
						state_q    <= (cls_q == itp_pkg::CLS_END) ? S_MARK : S_IDLE;
					end
				end

				S_MARK: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign postfix.valid        = out_vld_q;
	assign postfix.symbol       = symbol_q;
	assign postfix.symbol_valid = symbol_valid_q;
	assign postfix.expr_end     = expr_end_q;
	assign postfix.last         = last_q;
	assign postfix.error_code   = error_code_q;

	// Checks
	`ITP_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(STACK_DEPTH), "stack count above depth")
	`ITP_ASSERT_NOW(a_idle_hold_empty, state_q == S_IDLE, !hold_vld_q, "held symbol left at idle")
	`ITP_ASSERT_NOW(a_marker_last, out_vld_q && expr_end_q, last_q && !symbol_valid_q,
		"end marker must be last and carry no symbol")
	`ITP_ASSERT_NEXT(a_marker_clears, mark_load, count_q == '0 && pending_q == itp_pkg::ERR_NONE,
		"stack or error not cleared after end marker")

endmodule

### test/infix_to_postfix_converter_core_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Infix-to-postfix converter checker
// Watches the infix and postfix channels, runs a shunting-yard model of
// the core on every accepted infix word and compares each postfix word,
// in order and field by field, with the oldest predicted one.
// ---------------------------------------------------------------------------
module infix_to_postfix_converter_core_checker
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	itp_in_if    infix,
	itp_out_if   postfix,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic [7:0] symbol;
		logic       symbol_valid;
		logic       expr_end;
		logic       last;
		logic [1:0] error_code;
	} postfix_word_t;

	// Model state
	op_code_t      op_stack [STACK_DEPTH];
	int            stack_fill;
	err_code_t     first_err;

	// Predicted postfix words, oldest first
	postfix_word_t postfix_expect_q[$];

	// Newest predicted word, held back until we know whether it is the last
	postfix_word_t held_word;
	logic          held_ok;

	int            mismatches = 0;

	assign fail_count = mismatches;

	// Precedence: '(' sits below every operator so it is never popped by one
	function automatic int prec_of(op_code_t code);
		if (code == OP_MUL || code == OP_DIV) begin
			return 3;
		end else if (code == OP_ADD || code == OP_SUB) begin
			return 2;
		end
		return 1;
	endfunction

	function automatic logic [7:0] char_of(op_code_t code);
		logic [7:0] c;
		c = CHAR_NUL;
		case (code)
			OP_ADD:  c = CHAR_ADD;
			OP_SUB:  c = CHAR_SUB;
			OP_MUL:  c = CHAR_MUL;
			OP_DIV:  c = CHAR_DIV;
			default: c = CHAR_OPEN;
		endcase
		return c;
	endfunction

	// Keep only the first error of an expression
	task automatic note_error(input err_code_t err);
		if (first_err == ERR_NONE)
			first_err = err;
	endtask

	// Drop the push when the stack is full
	task automatic push_op(input op_code_t code);
		if (stack_fill >= STACK_DEPTH) begin
			note_error(ERR_OVERFLOW);
		end else begin
			op_stack[stack_fill] = code;
			stack_fill++;
		end
	endtask

	task automatic emit_word(input logic [7:0] sym, input logic is_end, input err_code_t err);
		if (held_ok)
			postfix_expect_q.push_back(held_word);
		held_word.symbol       = sym;
		held_word.symbol_valid = !is_end;
		held_word.expr_end     = is_end;
		held_word.last         = 1'b0;
		held_word.error_code   = err;
		held_ok = 1'b1;
	endtask

	// Predict the postfix words of one infix word
	task automatic convert_word(input logic kind, input logic [7:0] ch);
		op_code_t top;
		op_code_t code;
		logic     matched;
		logic     is_op;
		held_ok = 1'b0;
		matched = 1'b0;
		is_op   = 1'b0;
		code    = OP_ADD;
		if (kind) begin
			// flush the stack, drop leftover opens, then close with the marker
			while (stack_fill > 0) begin
				stack_fill--;
				top = op_stack[stack_fill];
				if (top == OP_OPEN) begin
					note_error(ERR_OPEN);
				end else begin
					emit_word(char_of(top), 1'b0, ERR_NONE);
				end
			end
			emit_word(CHAR_NUL, 1'b1, first_err);
			first_err = ERR_NONE;
		end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
			emit_word(ch, 1'b0, ERR_NONE);
		end else if (ch == CHAR_OPEN) begin
			push_op(OP_OPEN);
		end else if (ch == CHAR_CLOSE) begin
			// pop down to the matching open, or to the empty stack
			while (stack_fill > 0 && !matched) begin
				stack_fill--;
				top = op_stack[stack_fill];
				if (top == OP_OPEN) begin
					matched = 1'b1;
				end else begin
					emit_word(char_of(top), 1'b0, ERR_NONE);
				end
			end
			if (!matched)
				note_error(ERR_CLOSE);
		end else begin
			case (ch)
				CHAR_ADD: begin code = OP_ADD; is_op = 1'b1; end
				CHAR_SUB: begin code = OP_SUB; is_op = 1'b1; end
				CHAR_MUL: begin code = OP_MUL; is_op = 1'b1; end
				CHAR_DIV: begin code = OP_DIV; is_op = 1'b1; end
				default:  is_op = 1'b0;
			endcase
			// pop equal or higher precedence, then push
			if (is_op) begin
				while (stack_fill > 0 && prec_of(op_stack[stack_fill - 1]) >= prec_of(code)) begin
					stack_fill--;
					emit_word(char_of(op_stack[stack_fill]), 1'b0, ERR_NONE);
				end
				push_op(code);
			end
		end
		// mark the final word of this infix word
		if (held_ok) begin
			held_word.last = 1'b1;
			postfix_expect_q.push_back(held_word);
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_word();
		postfix_word_t want;
		if (postfix_expect_q.size() == 0) begin
			$error("unexpected postfix word: symbol %0h, expr_end %b, error_code %0d",
				postfix.symbol, postfix.expr_end, postfix.error_code);
			mismatches++;
		end else begin
			want = postfix_expect_q.pop_front();
			compare_field("symbol", want.symbol, postfix.symbol);
			compare_field("symbol_valid", 8'(want.symbol_valid), 8'(postfix.symbol_valid));
			compare_field("expr_end", 8'(want.expr_end), 8'(postfix.expr_end));
			compare_field("last", 8'(want.last), 8'(postfix.last));
			compare_field("error_code", 8'(want.error_code), 8'(postfix.error_code));
		end
	endtask

	// Compare outgoing words, then predict from the incoming word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_fill = 0;
			first_err  = ERR_NONE;
			postfix_expect_q.delete();
			pending <= 0;
		end else begin
			if (postfix.valid && postfix.ready)
				check_word();
			if (infix.valid && infix.ready)
				convert_word(infix.kind, infix.ch);
			pending <= postfix_expect_q.size();
		end
	end

endmodule

### test/infix_to_postfix_converter_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Infix-to-postfix converter testbench
// Feeds directed expressions, then random well-formed, deeply nested,
// damaged and junk character streams with random idling on both channels;
// the checker beside the core predicts and compares every postfix word.
// ---------------------------------------------------------------------------
module infix_to_postfix_converter_core_tb;
	import itp_pkg::*;

	localparam int WORD_TARGET  = 450;
	localparam int PAUSE_AT     = 150;
	localparam int HOLD_AT      = 250;
	localparam int CALM_AT      = 360;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam logic KIND_CHAR  = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
		logic       counted;
	} infix_word_t;

	logic        clk;
	logic        arst_n;
	int          fail_count;
	int          pending;
	logic        calm;
	logic        rx_hold;
	int          words_sent;
	infix_word_t infix_q[$];

	itp_in_if  infix_ch ();
	itp_out_if postfix_ch ();

	infix_to_postfix_converter_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.infix   (infix_ch),
		.postfix (postfix_ch)
	);

	infix_to_postfix_converter_core_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.infix      (infix_ch),
		.postfix    (postfix_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic infix_word_t word_of(input logic kind, input logic [7:0] ch);
		infix_word_t w;
		w.kind    = kind;
		w.ch      = ch;
		w.counted = 1'b1;
		return w;
	endfunction

	function automatic logic [7:0] random_digit();
		return CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_op();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0:       c = CHAR_ADD;
			1:       c = CHAR_SUB;
			2:       c = CHAR_MUL;
			default: c = CHAR_DIV;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] stray_char();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0:       c = CHAR_OPEN;
			1:       c = CHAR_CLOSE;
			2:       c = random_op();
			default: c = 8'($urandom_range(0, 255));
		endcase
		return c;
	endfunction

	task automatic queue_char(input logic [7:0] ch);
		infix_q.push_back(word_of(KIND_CHAR, ch));
	endtask

	task automatic queue_end();
		infix_q.push_back(word_of(KIND_END, 8'($urandom_range(0, 255))));
	endtask

	task automatic queue_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			queue_char(s[i]);
	endtask

	// Well-formed expression with random nesting, closed by an end word
	task automatic queue_expression(input int max_ops);
		int nest;
		int n;
		nest = 0;
		for (n = 0; n <= max_ops; n++) begin
			while (nest < 6 && $urandom_range(0, 3) == 0) begin
				queue_char(CHAR_OPEN);
				nest++;
			end
			queue_char(random_digit());
			while (nest > 0 && $urandom_range(0, 2) == 0) begin
				queue_char(CHAR_CLOSE);
				nest--;
			end
			if (n < max_ops)
				queue_char(random_op());
		end
		while (nest > 0) begin
			queue_char(CHAR_CLOSE);
			nest--;
		end
		queue_end();
	endtask

	// Deep nesting that can run the stack full and pops long trains at the end
	task automatic queue_nesting(input int levels);
		int i;
		int closes;
		for (i = 0; i < levels; i++) begin
			queue_char(CHAR_OPEN);
			if ($urandom_range(0, 1) == 1) begin
				queue_char(random_digit());
				queue_char(random_op());
			end
		end
		queue_char(random_digit());
		closes = $urandom_range(0, levels + 2);
		for (i = 0; i < closes; i++) begin
			queue_char(CHAR_CLOSE);
			if ($urandom_range(0, 3) == 0) begin
				queue_char(random_op());
				queue_char(random_digit());
			end
		end
		queue_end();
	endtask

	// Well-formed expression with one to three characters replaced, dropped or added
	task automatic queue_broken();
		int start;
		int idx;
		int m;
		int n_mut;
		start = infix_q.size();
		queue_expression($urandom_range(1, 6));
		n_mut = $urandom_range(1, 3);
		for (m = 0; m < n_mut; m++) begin
			idx = $urandom_range(start, infix_q.size() - 2);
			case ($urandom_range(0, 3))
				0: infix_q[idx] = word_of(KIND_CHAR, stray_char());
				1: begin
					if (infix_q.size() - start > 2)
						infix_q.delete(idx);
				end
				2: infix_q.insert(idx, word_of(KIND_CHAR, CHAR_CLOSE));
				default: infix_q.insert(idx, word_of(KIND_CHAR, CHAR_OPEN));
			endcase
		end
	endtask

	// Junk bytes, now and then an end word
	task automatic queue_noise();
		infix_word_t w;
		int n;
		int i;
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++) begin
			w = word_of(($urandom_range(0, 7) == 0) ? KIND_END : KIND_CHAR,
				8'($urandom_range(0, 255)));
			w.counted = 1'b0;
			infix_q.push_back(w);
		end
	endtask

	// Offer every queued word, with random gaps unless calm
	task automatic send_queued();
		infix_word_t w;
		while (infix_q.size() > 0) begin
			w = infix_q.pop_front();
			if (!calm && $urandom_range(0, 7) == 0) begin
				infix_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			infix_ch.valid <= 1'b1;
			infix_ch.kind  <= w.kind;
			infix_ch.ch    <= w.ch;
			@(posedge clk);
			while (!infix_ch.ready) @(posedge clk);
			if (w.counted)
				words_sent++;
		end
	endtask

	// Hold the sender until every predicted word has come out
	task automatic wait_empty();
		infix_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Postfix receiver: random stalls, one long hold on request
	initial begin
		postfix_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_hold) begin
				postfix_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				postfix_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				postfix_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 32)) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int   pick;
		logic paused_once;
		logic held_once;
		arst_n         = 1'b0;
		calm           = 1'b0;
		rx_hold        = 1'b0;
		words_sent     = 0;
		paused_once    = 1'b0;
		held_once      = 1'b0;
		infix_ch.valid <= 1'b0;
		infix_ch.kind  <= KIND_CHAR;
		infix_ch.ch    <= CHAR_NUL;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ignored extremes, all operators with precedence and
		// parentheses, unmatched close with a later leftover open (first
		// error wins), leftover open alone, empty expression
		queue_char(CHAR_NUL);
		queue_char(8'hFF);
		queue_text("0+9*(1-2)/3");
		queue_end();
		queue_text("7-8)(");
		queue_end();
		queue_text("(5+6");
		queue_end();
		queue_end();
		send_queued();

		// Overflow: more opens than the stack holds
		queue_nesting(STACK_DEPTH_DEF + 2);
		send_queued();

		// Random mix, mostly well-formed
		while (words_sent < WORD_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				queue_expression($urandom_range(1, 8));
			end else if (pick < 61) begin
				queue_nesting($urandom_range(8, 40));
			end else if (pick < 82) begin
				queue_broken();
			end else begin
				queue_noise();
			end
			send_queued();

			if (!paused_once && words_sent >= PAUSE_AT) begin
				paused_once = 1'b1;
				wait_empty();
			end
			// Back up the core against a long receiver hold
			if (!held_once && words_sent >= HOLD_AT) begin
				held_once = 1'b1;
				rx_hold   = 1'b1;
				repeat (40) queue_char(random_digit());
				send_queued();
			end
			if (words_sent >= CALM_AT)
				calm = 1'b1;
		end
		queue_end();
		send_queued();

		wait_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
